[hdl/sst_pkg.sv]
// Package for the sorted set table: field widths, command and status codes,
// and the result record. Depends on nothing; every other file uses it.
`default_nettype none

package sst_pkg;

    // Field widths of one command and one result.
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEST   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      present;
        logic signed [VALUE_W-1:0] element;
        logic [COUNT_W-1:0]        count;
    } t_result;

endpackage

`default_nettype wire

[hdl/sst_in_if.sv]
// Command channel of the sorted set table: valid/ready plus the command fields.
// Depends on sst_pkg for the field widths.
`default_nettype none

interface sst_in_if;
    logic                               valid;
    logic                               ready;
    logic [sst_pkg::CMD_W-1:0]          cmd;
    logic signed [sst_pkg::VALUE_W-1:0] value;
    logic [sst_pkg::INDEX_W-1:0]        index;

    modport source (output valid, output cmd, output value, output index, input ready);
    modport sink   (input valid, input cmd, input value, input index, output ready);
endinterface

`default_nettype wire

[hdl/sst_out_if.sv]
// Result channel of the sorted set table: valid/ready plus the result fields.
// Depends on sst_pkg for the field widths.
`default_nettype none

interface sst_out_if;
    logic                               valid;
    logic                               ready;
    logic [sst_pkg::STATUS_W-1:0]       status;
    logic                               present;
    logic signed [sst_pkg::VALUE_W-1:0] element;
    logic [sst_pkg::COUNT_W-1:0]        count;

    modport source (output valid, output status, output present, output element,
                    output count, input ready);
    modport sink   (input valid, input status, input present, input element,
                    input count, output ready);
endinterface

`default_nettype wire

[hdl/sst_mem.sv]
// Member store of the sorted set table: one write port and one read port,
// read data registered. Depends on sst_pkg for the value width.
`default_nettype none

module sst_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [AW-1:0]                      i_waddr,
    input  wire logic signed [sst_pkg::VALUE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                      i_raddr,
    output logic signed [sst_pkg::VALUE_W-1:0]      o_rdata
);
    import sst_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, read data registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/sst_ctrl.sv]
// Sequencer of the sorted set table: linear search, shift-up insertion and
// indexed read over the member store. Depends on sst_pkg and sst_in_if.
`default_nettype none

module sst_ctrl #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned AW       = 6,
    parameter int unsigned CW       = 7
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    sst_in_if.sink                                  i_in,
    // Member store ports.
    output logic                                    o_we,
    output logic [AW-1:0]                           o_waddr,
    output logic signed [sst_pkg::VALUE_W-1:0]      o_wdata,
    output logic [AW-1:0]                           o_raddr,
    input  wire logic signed [sst_pkg::VALUE_W-1:0] i_rdata,
    // Finished result towards the output stage.
    output logic                                    o_res_valid,
    input  wire logic                               i_res_ready,
    output sst_pkg::t_result                        o_res
);
    import sst_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SRCH_RD  = 3'd1;
    localparam logic [2:0] S_SRCH_CMP = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_READ     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [2:0]                r_state, n_state;
    logic [CMD_W-1:0]          r_cmd, n_cmd;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [CW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_k, n_k;
    logic [CW-1:0]             r_count, n_count;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic                      r_present, n_present;
    logic signed [VALUE_W-1:0] r_element, n_element;

    logic                      w_accept;
    logic [AW+INDEX_W-1:0]     w_index_ext;
    logic [CW+INDEX_W-1:0]     w_index_cmp;
    logic [CW+INDEX_W-1:0]     w_count_cmp;
    logic                      w_index_ok;
    logic [CW+COUNT_W-1:0]     w_count_ext;
    logic [CW-1:0]             w_k_dec;
    logic                      w_srch_end;
    logic                      w_hit;

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);

    // Range check and address of an indexed read.
    assign w_index_ext = {{AW{1'b0}}, i_in.index};
    assign w_index_cmp = {{CW{1'b0}}, i_in.index};
    assign w_count_cmp = {{INDEX_W{1'b0}}, r_count};
    assign w_index_ok  = (w_index_cmp < w_count_cmp);
    assign w_k_dec     = r_k - CW'(1);
    assign w_count_ext = {{COUNT_W{1'b0}}, r_count};

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_idx      = r_idx;
        n_k        = r_k;
        n_count    = r_count;
        n_status   = r_status;
        n_present  = r_present;
        n_element  = r_element;
        o_we       = 1'b0;
        o_waddr    = r_idx[AW-1:0];
        o_wdata    = r_value;
        o_raddr    = w_index_ext[AW-1:0];
        w_srch_end = 1'b0;
        w_hit      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd     = i_in.cmd;
                    n_value   = i_in.value;
                    n_idx     = '0;
                    n_status  = ST_OK;
                    n_present = 1'b0;
                    n_element = '0;
                    unique case (i_in.cmd)
                        CMD_INSERT, CMD_TEST: begin
                            n_state = S_SRCH_RD;
                        end
                        CMD_READ: begin
                            if (w_index_ok) begin
                                n_state = S_READ;
                            end else begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                o_raddr = r_idx[AW-1:0];
                if (r_idx == r_count) begin
                    w_srch_end = 1'b1;
                end else begin
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_rdata == r_value) begin
                    w_srch_end = 1'b1;
                    w_hit      = 1'b1;
                end else if (r_value < i_rdata) begin
                    w_srch_end = 1'b1;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                o_raddr = w_k_dec[AW-1:0];
                if (r_k == r_idx) begin
                    // Gap reached: place the new value and grow the set.
                    o_we    = 1'b1;
                    o_waddr = r_idx[AW-1:0];
                    o_wdata = r_value;
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_we    = 1'b1;
                o_waddr = r_k[AW-1:0];
                o_wdata = i_rdata;
                n_k     = w_k_dec;
                n_state = S_SHIFT_RD;
            end
            S_READ: begin
                n_element = i_rdata;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of a search: r_idx is the first slot not below the value.
        if (w_srch_end) begin
            n_state = S_DONE;
            if (r_cmd == CMD_TEST) begin
                n_present = w_hit;
            end else if (w_hit) begin
                n_status  = ST_DUPLICATE;
                n_present = 1'b1;
            end else if (r_count == FULL_COUNT) begin
                n_status = ST_FULL;
            end else begin
                n_k     = r_count;
                n_state = S_SHIFT_RD;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_value   <= n_value;
        r_idx     <= n_idx;
        r_k       <= n_k;
        r_status  <= n_status;
        r_present <= n_present;
        r_element <= n_element;
    end

    assign o_res_valid   = (r_state == S_DONE);
    assign o_res.status  = r_status;
    assign o_res.present = r_present;
    assign o_res.element = r_element;
    assign o_res.count   = w_count_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

[hdl/sorted_set_table.sv]
// Sorted set table: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a single-port-read, single-port-write memory and serves
// one command at a time. A membership test or an insert scans the members from
// the smallest, reading each member from memory and then comparing it; an
// insert that adds its value then moves every larger member up one slot, each
// move a memory read and then a write, and writes the new value into the gap.
// A read within the count takes the member from memory; a read at or beyond
// the count returns a range status. The registered read of the memory is
// waited for before every compare and every move. A new command is taken as
// soon as the previous result has gone to the output register, while that
// result still waits for its transfer. The count field carries the low seven
// bits of the member count.
`default_nettype none

module sorted_set_table #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sst_in_if.sink    i_in,
    sst_out_if.source o_out
);
    import sst_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic signed [VALUE_W-1:0] w_wdata;
    logic [AW-1:0]             w_raddr;
    logic signed [VALUE_W-1:0] w_rdata;
    logic                      w_res_valid;
    logic                      w_res_ready;
    t_result                   w_res;
    logic                      r_out_valid;
    t_result                   r_out;

    sst_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sst_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Output register: free when empty or when its transfer happens now.
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_out.status;
    assign o_out.present = r_out.present;
    assign o_out.element = r_out.element;
    assign o_out.count   = r_out.count;

endmodule

`default_nettype wire

[bench/sorted_set_table_tb.sv]
// Self-checking testbench for the sorted set table: directed and random commands,
// a shadow copy of the table predicting every result, and random stalls on both channels.
// Depends on sst_pkg, sst_in_if, sst_out_if and sorted_set_table from the hdl folder.
`default_nettype none

module sorted_set_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int unsigned CAPACITY     = 64;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned TAIL_ITEMS   = 100;
    localparam int unsigned DRAIN_CYCLES = 4000;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } t_command;

    logic i_clk;
    logic i_rst_n;

    sst_in_if  cmd_if ();
    sst_out_if res_if ();

    sorted_set_table #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_if),
        .o_out  (res_if)
    );

    // Commands waiting to be driven, and results awaited in order.
    t_command queued_cmds[$];
    t_result  awaited_results[$];

    // Shadow copy of the table contents.
    logic signed [VALUE_W-1:0] shadow_members[CAPACITY];
    int unsigned               shadow_size = 0;

    int unsigned mismatch_count = 0;
    logic        cmd_taken = 1'b0;
    t_command    drive_cmd;
    t_result     want;

    // Burst state of the command source and the result sink.
    int unsigned src_gap = 0;
    int unsigned src_stretch = 0;
    bit          src_quiet = 1'b0;
    int unsigned snk_gap = 0;
    int unsigned snk_stretch = 0;
    bit          snk_quiet = 1'b0;

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Applies one command to the shadow table and returns the result it must produce.
    function automatic t_result table_response(input logic [CMD_W-1:0] cmd,
                                               input logic signed [VALUE_W-1:0] value,
                                               input logic [INDEX_W-1:0] index);
        t_result     r;
        int unsigned slot;
        bit          hit;
        r    = '0;
        slot = 0;
        hit  = 1'b0;
        // Find the first member not below the value.
        while (slot < shadow_size) begin
            if (shadow_members[slot] == value) begin
                hit = 1'b1;
                break;
            end
            if (value < shadow_members[slot]) begin
                break;
            end
            slot++;
        end
        unique case (cmd)
            CMD_INSERT: begin
                if (hit) begin
                    r.status  = ST_DUPLICATE;
                    r.present = 1'b1;
                end else if (shadow_size >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int unsigned k = shadow_size; k > slot; k--) begin
                        shadow_members[k] = shadow_members[k-1];
                    end
                    shadow_members[slot] = value;
                    shadow_size++;
                end
            end
            CMD_TEST: begin
                r.present = hit;
            end
            CMD_READ: begin
                if (index < shadow_size) begin
                    r.element = shadow_members[index];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(shadow_size);
        return r;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd,
                             input logic signed [VALUE_W-1:0] value,
                             input logic [INDEX_W-1:0] index);
        t_command c;
        c.cmd   = cmd;
        c.value = value;
        c.index = index;
        queued_cmds.push_back(c);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Known values on every input from the start.
    initial begin
        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.cmd    = CMD_NOP;
        cmd_if.value  = '0;
        cmd_if.index  = '0;
        res_if.ready  = 1'b0;
    end

    // Command driver: holds an item until its transfer, then picks the next or idles.
    always @(negedge i_clk) begin
        if (i_rst_n && !(cmd_if.valid === 1'b1 && !cmd_taken)) begin
            if (src_stretch == 0) begin
                src_stretch = $urandom_range(20, 300);
                src_quiet   = ($urandom_range(0, 2) == 0);
            end else begin
                src_stretch--;
            end
            if (src_gap > 0) begin
                src_gap--;
                cmd_if.valid <= 1'b0;
            end else if (queued_cmds.size() == 0) begin
                cmd_if.valid <= 1'b0;
            end else if (!src_quiet && queued_cmds.size() > TAIL_ITEMS &&
                         $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 19) - 1;
                cmd_if.valid <= 1'b0;
            end else begin
                drive_cmd = queued_cmds.pop_front();
                cmd_if.cmd   <= drive_cmd.cmd;
                cmd_if.value <= drive_cmd.value;
                cmd_if.index <= drive_cmd.index;
                cmd_if.valid <= 1'b1;
            end
        end
    end

    // Result sink: ready with stall bursts, none in the tail of the run.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (snk_stretch == 0) begin
                snk_stretch = $urandom_range(20, 300);
                snk_quiet   = ($urandom_range(0, 2) == 0);
            end else begin
                snk_stretch--;
            end
            if (snk_gap > 0) begin
                snk_gap--;
                res_if.ready <= 1'b0;
            end else if (!snk_quiet && queued_cmds.size() > TAIL_ITEMS &&
                         $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(1, 19) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each command transfer and checks each result transfer.
    always @(posedge i_clk) begin
        cmd_taken <= (cmd_if.valid === 1'b1) && (cmd_if.ready === 1'b1);
        if (i_rst_n) begin
            if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
                awaited_results.push_back(table_response(cmd_if.cmd, cmd_if.value,
                                                         cmd_if.index));
            end
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transfer with no command outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    if (res_if.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  res_if.status, want.status));
                    end
                    if (res_if.present !== want.present) begin
                        report_mismatch($sformatf("present got %0b expected %0b",
                                                  res_if.present, want.present));
                    end
                    if (res_if.element !== want.element) begin
                        report_mismatch($sformatf("element got %h expected %h",
                                                  res_if.element, want.element));
                    end
                    if (res_if.count !== want.count) begin
                        report_mismatch($sformatf("count got %0d expected %0d",
                                                  res_if.count, want.count));
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic signed [VALUE_W-1:0] inserted_pool[$];
        logic signed [VALUE_W-1:0] val;
        logic [INDEX_W-1:0]        idx;
        int unsigned               useful;
        int unsigned               sel;
        int unsigned               drain;

        // Directed part: empty table, extremes, duplicates, misses and range errors.
        queue_cmd(CMD_READ,   '0, 6'd0);
        queue_cmd(CMD_READ,   '0, 6'd63);
        queue_cmd(CMD_TEST,   32'sd0, 6'd0);
        queue_cmd(CMD_NOP,    32'shFFFFFFFF, 6'd63);
        queue_cmd(CMD_INSERT, 32'sd0, 6'd0);
        queue_cmd(CMD_INSERT, 32'sh80000000, 6'd63);
        queue_cmd(CMD_INSERT, 32'sh7FFFFFFF, 6'd0);
        queue_cmd(CMD_INSERT, -32'sd1, 6'd0);
        queue_cmd(CMD_INSERT, 32'sd1, 6'd0);
        queue_cmd(CMD_INSERT, 32'sd0, 6'd0);
        queue_cmd(CMD_INSERT, 32'sh80000000, 6'd0);
        queue_cmd(CMD_TEST,   32'sh7FFFFFFF, 6'd0);
        queue_cmd(CMD_TEST,   32'sd2, 6'd0);
        queue_cmd(CMD_TEST,   32'sh80000000, 6'd0);
        queue_cmd(CMD_READ,   '0, 6'd0);
        queue_cmd(CMD_READ,   '0, 6'd4);
        queue_cmd(CMD_READ,   '0, 6'd5);
        queue_cmd(CMD_READ,   '0, 6'd63);
        queue_cmd(CMD_NOP,    '0, 6'd0);
        queue_cmd(CMD_INSERT, 32'sh40000000, 6'd0);
        queue_cmd(CMD_INSERT, 32'shC0000000, 6'd0);
        queue_cmd(CMD_READ,   '0, 6'd3);
        queue_cmd(CMD_NOP,    $urandom, INDEX_W'($urandom));
        inserted_pool = '{32'sd0, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 32'sd1,
                          32'sh40000000, 32'shC0000000};

        // Random part: the table fills early, then full-table inserts, tests and reads.
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            val = $urandom;
            idx = INDEX_W'($urandom_range(0, 63));
            if (sel < 50) begin
                if ($urandom_range(0, 5) == 0) begin
                    val = inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
                end else begin
                    if ($urandom_range(0, 9) == 0) begin
                        // Clustered small values give neighbours and repeats.
                        val = $urandom_range(0, 16) - 8;
                    end else if ($urandom_range(0, 19) == 0) begin
                        val = ($urandom_range(0, 1) == 0) ? 32'sh80000001 : 32'sh7FFFFFFE;
                    end
                    inserted_pool.push_back(val);
                end
                queue_cmd(CMD_INSERT, val, idx);
                useful++;
            end else if (sel < 70) begin
                if ($urandom_range(0, 1) == 0) begin
                    val = inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
                end
                queue_cmd(CMD_TEST, val, idx);
                useful++;
            end else if (sel < 90) begin
                if ($urandom_range(0, 1) == 0 && inserted_pool.size() < 64) begin
                    idx = INDEX_W'($urandom_range(0, inserted_pool.size()));
                end
                queue_cmd(CMD_READ, val, idx);
                useful++;
            end else begin
                queue_cmd(CMD_NOP, val, idx);
                useful++;
            end
        end

        // Reset, then release at a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to be transferred.
        while (queued_cmds.size() != 0 || cmd_if.valid === 1'b1) begin
            @(posedge i_clk);
        end

        // Let the last results come out, within a bound.
        drain = 0;
        while (awaited_results.size() != 0 && drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        if (awaited_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never delivered", awaited_results.size()));
        end
        repeat (300) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("sorted_set_table_tb passed");
        end else begin
            $display("sorted_set_table_tb failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3ms;
        $display("sorted_set_table_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

[sorted_set_table.f]
hdl/sst_pkg.sv
hdl/sst_in_if.sv
hdl/sst_out_if.sv
hdl/sst_mem.sv
hdl/sst_ctrl.sv
hdl/sorted_set_table.sv
bench/sorted_set_table_tb.sv
